>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dsmc_pkg.sv
// shared constants, command codes and structs for the set member check block
`timescale 1ns / 1ps

package dsmc_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int CMD_W         = 2;
  localparam int NODE_W        = 6;
  localparam int ROW_W         = 64;
  localparam int COUNT_W       = 7;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_ADD   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node;
    logic [ROW_W-1:0]  row_bits;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] node;
    logic [ROW_W-1:0]  row_bits;
  } adj_wr_t;

endpackage

>>> src/dsmc_if.sv
// valid/ready channel interfaces: command beats, result beats, node_count writes
`timescale 1ns / 1ps

interface dsmc_req_if;
  logic                          valid;
  logic                          ready;
  logic [dsmc_pkg::CMD_W-1:0]    cmd;
  logic [dsmc_pkg::NODE_W-1:0]   node;
  logic [dsmc_pkg::ROW_W-1:0]    row_bits;

  modport source (output valid, cmd, node, row_bits, input ready);
  modport sink   (input valid, cmd, node, row_bits, output ready);
endinterface

interface dsmc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          bad_node;
  logic [dsmc_pkg::COUNT_W-1:0]  set_size;
  logic [dsmc_pkg::ROW_W-1:0]    member_mask;

  modport source (output valid, accepted, bad_node, set_size, member_mask, input ready);
  modport sink   (input valid, accepted, bad_node, set_size, member_mask, output ready);
endinterface

interface dsmc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dsmc_pkg::COUNT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> src/dissociation_set_member_check.sv
// Path: a command beat goes through the input register and then the result register to its result beat.
// Throughput: one command per cycle unless the result beat stalls; the join test reads one
// adjacency row per cycle and uses per-row member-neighbor flags, so no second row read is needed.
// Reset: member set and count cleared, node_count set to 64, every adjacency row reads
// zero through per-row valid bits; no clearing pass, commands accepted right after reset.
`timescale 1ns / 1ps

module dissociation_set_member_check #(
  parameter int MAX_NODES = dsmc_pkg::MAX_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dsmc_req_if.sink   req,
  dsmc_rsp_if.source rsp,
  dsmc_cfg_if.sink   cfg
);

  logic                 s_valid;
  dsmc_pkg::item_t      s_item;
  logic                 out_valid;
  logic                 advance;
  logic                 step;
  dsmc_pkg::adj_wr_t    adj_wr;
  logic [MAX_NODES-1:0] members;
  logic [MAX_NODES-1:0] rd_row;
  logic [MAX_NODES-1:0] crowded;

  // pipeline flow control
  assign advance   = !out_valid || rsp.ready;
  assign step      = s_valid && advance;
  assign req.ready = !s_valid || advance;
  assign cfg.ready = 1'b1;

  // input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s_item.cmd      <= req.cmd;
      s_item.node     <= req.node;
      s_item.row_bits <= req.row_bits;
    end
  end

  dsmc_adj_cells #(
    .MAX_NODES (MAX_NODES)
  ) u_adj_cells (
    .clk     (clk),
    .rst     (rst),
    .wr      (adj_wr),
    .rd_node (s_item.node),
    .members (members),
    .rd_row  (rd_row),
    .crowded (crowded)
  );

  dsmc_set_unit #(
    .MAX_NODES (MAX_NODES)
  ) u_set_unit (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (s_item),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.data),
    .rd_row      (rd_row),
    .crowded     (crowded),
    .out_ready   (rsp.ready),
    .adj_wr      (adj_wr),
    .members     (members),
    .out_valid   (out_valid),
    .accepted    (rsp.accepted),
    .bad_node    (rsp.bad_node),
    .set_size    (rsp.set_size),
    .member_mask (rsp.member_mask)
  );

  assign rsp.valid = out_valid;

endmodule

>>> src/dsmc_adj_cells.sv
// adjacency row cells: per-row storage, neighbor-of-member flags and row select
`timescale 1ns / 1ps

module dsmc_adj_cells #(
  parameter int MAX_NODES = dsmc_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dsmc_pkg::adj_wr_t           wr,
  input  logic [dsmc_pkg::NODE_W-1:0] rd_node,
  input  logic [MAX_NODES-1:0]        members,
  output logic [MAX_NODES-1:0]        rd_row,
  output logic [MAX_NODES-1:0]        crowded
);

  logic [MAX_NODES-1:0] gated [MAX_NODES];

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_row
    localparam logic [dsmc_pkg::NODE_W-1:0] K = dsmc_pkg::NODE_W'(k);

    logic                 vld;
    logic [MAX_NODES-1:0] row_q;
    logic [MAX_NODES-1:0] row_k;
    logic                 hit_wr;

    assign hit_wr = wr.en && (wr.node == K);

    // valid bit: a row never loaded reads as zero
    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (hit_wr) begin
        vld <= 1'b1;
      end
    end

    // row storage, bits past the node range dropped
    always_ff @(posedge clk) begin
      if (hit_wr) begin
        row_q <= wr.row_bits[MAX_NODES-1:0];
      end
    end

    assign row_k = vld ? row_q : '0;

    // this node already has a member neighbor (self loop masked)
    assign crowded[k] = |(row_k & members & ~(MAX_NODES'(1) << k));

    // row select for the node under test
    assign gated[k] = (rd_node == K) ? row_k : '0;
  end

  // or-combine the selected row
  always_comb begin
    rd_row = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      rd_row = rd_row | gated[k];
    end
  end

endmodule

>>> src/dsmc_set_unit.sv
// vertex set state, join decision, node_count register and result register
`timescale 1ns / 1ps

module dsmc_set_unit #(
  parameter int MAX_NODES = dsmc_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  dsmc_pkg::item_t              item,
  input  logic                         cfg_we,
  input  logic [dsmc_pkg::COUNT_W-1:0] cfg_data,
  input  logic [MAX_NODES-1:0]         rd_row,
  input  logic [MAX_NODES-1:0]         crowded,
  input  logic                         out_ready,
  output dsmc_pkg::adj_wr_t            adj_wr,
  output logic [MAX_NODES-1:0]         members,
  output logic                         out_valid,
  output logic                         accepted,
  output logic                         bad_node,
  output logic [dsmc_pkg::COUNT_W-1:0] set_size,
  output logic [dsmc_pkg::ROW_W-1:0]   member_mask
);

  logic [dsmc_pkg::COUNT_W-1:0] node_count;
  logic [dsmc_pkg::COUNT_W-1:0] total;
  logic [dsmc_pkg::COUNT_W-1:0] total_next;
  logic [MAX_NODES-1:0]         members_next;
  logic [MAX_NODES-1:0]         self;
  logic [MAX_NODES-1:0]         near;
  logic [dsmc_pkg::COUNT_W-1:0] node_ext;
  logic                         bad;
  logic                         is_member;
  logic                         multi;
  logic                         blocked;
  logic                         join_ok;
  logic                         ok;
  logic                         flag;
  logic                         load_en;

  // node_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= dsmc_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  // one-hot of the node under test
  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      self[k] = (item.node == dsmc_pkg::NODE_W'(k));
    end
  end

  // range check against node_count and the array size
  assign node_ext = dsmc_pkg::COUNT_W'(item.node);
  assign bad = (node_ext >= node_count) || (node_ext >= dsmc_pkg::COUNT_W'(MAX_NODES));

  // join test: a member passes; else at most one member neighbor, and that one has none
  assign is_member = |(members & self);
  assign near      = rd_row & members & ~self;
  assign multi     = |(near & (near - MAX_NODES'(1)));
  assign blocked   = |(near & crowded);
  assign join_ok   = is_member || (!multi && !blocked);

  // command decode
  always_comb begin
    ok           = 1'b0;
    flag         = 1'b0;
    load_en      = 1'b0;
    members_next = members;
    total_next   = total;
    case (dsmc_pkg::cmd_t'(item.cmd))
      dsmc_pkg::CMD_LOAD: begin
        if (bad) begin
          flag = 1'b1;
        end else begin
          ok      = 1'b1;
          load_en = 1'b1;
        end
      end
      dsmc_pkg::CMD_CLEAR: begin
        ok           = 1'b1;
        members_next = '0;
        total_next   = '0;
      end
      dsmc_pkg::CMD_ADD: begin
        if (bad) begin
          flag = 1'b1;
        end else if (join_ok) begin
          ok = 1'b1;
          if (!is_member) begin
            members_next = members | self;
            total_next   = total + dsmc_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign adj_wr.en       = step && load_en;
  assign adj_wr.node     = item.node;
  assign adj_wr.row_bits = item.row_bits;

  // set state
  always_ff @(posedge clk) begin
    if (rst) begin
      members <= '0;
      total   <= '0;
    end else if (step) begin
      members <= members_next;
      total   <= total_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      accepted    <= ok;
      bad_node    <= flag;
      set_size    <= total_next;
      member_mask <= dsmc_pkg::ROW_W'(members_next);
    end
  end

endmodule

>>> src/dsmc_checker.sv
// port-level checker for the set member check block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsmc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         accepted,
  input logic                         bad_node,
  input logic [dsmc_pkg::COUNT_W-1:0] set_size,
  input logic [dsmc_pkg::ROW_W-1:0]   member_mask
);

  // a stalled result beat stays offered
  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped")

  // set size tracks the member mask
  `ASSERT_IMP(a_size_mask, clk, rst, rsp_valid, $countones(member_mask) == set_size, "size mismatch")

  // a flagged node is never accepted
  `ASSERT_IMP(a_bad_reject, clk, rst, rsp_valid && bad_node, !accepted, "bad node accepted")

  // set size never exceeds the reset node_count value
  `ASSERT_IMP(a_size_range, clk, rst, rsp_valid, set_size <= dsmc_pkg::NODE_COUNT_RST, "size too big")

endmodule

bind dissociation_set_member_check dsmc_checker u_dsmc_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .accepted    (rsp.accepted),
  .bad_node    (rsp.bad_node),
  .set_size    (rsp.set_size),
  .member_mask (rsp.member_mask)
);
